// ===== design/oale_pkg.sv =====
// Package for the ordered array list engine: sizes, operation and status
// codes, and the controller state type. No dependencies.
`default_nettype none

package oale_pkg;

  localparam int DEPTH         = 64;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int KEY_W         = 32;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int ENTRY_W       = KEY_W + PAYLOAD_WIDTH;

  // Stream widths
  localparam int MODE_W     = 2;
  localparam int POS_W      = 7;
  localparam int IN_PAY_W   = 32;
  localparam int STATUS_W   = 3;
  localparam int FOUND_W    = 32;
  localparam int OUT_CNT_W  = 7;
  localparam int S_DATA_W   = ((POS_W + KEY_W + IN_PAY_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((FOUND_W + OUT_CNT_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_EMPTY    = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_RANGE    = 3'd3,
    STATUS_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_DEL,
    ST_FIND,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/oale_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module oale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/ordered_array_list_engine.sv =====
// Top level of the ordered array list engine: sequencer around one entry RAM.
// Depends on oale_pkg and oale_ram.
//
//  channel   direction  tuser                   tdata
//  s_axis    in         mode [1:0]              position[6:0] key[38:7] payload[70:39]
//  m_axis    out        status [2:0]            found_payload[31:0] entry_count[38:32]
//
// Sequence: a rejected item or an unknown mode goes straight to its result, an insert or a
// remove at the tail passes through the drain state only, and any other insert, remove or
// find makes one RAM read per moved or scanned entry before the drain state.
// Reset clears the count and the control state; RAM contents stay undefined,
// and only entries below the count are ever read.
// A result waits in the output register while the next item is taken and
// worked on; only the hand-off of the following result stalls on m_axis_tready.
`default_nettype none

module ordered_array_list_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [oale_pkg::MODE_W-1:0]   s_axis_tuser,  // mode
  input  wire logic [oale_pkg::S_DATA_W-1:0] s_axis_tdata,  // position, key, payload, pad
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [oale_pkg::STATUS_W-1:0]      m_axis_tuser,  // status
  output logic [oale_pkg::M_DATA_W-1:0]      m_axis_tdata   // found_payload, entry_count, pad
);

  import oale_pkg::*;

  // Input field split
  logic [POS_W-1:0]    in_pos;
  logic [KEY_W-1:0]    in_key;
  logic [IN_PAY_W-1:0] in_pay;
  mode_t               in_mode;

  assign in_pos  = s_axis_tdata[POS_W-1:0];
  assign in_key  = s_axis_tdata[POS_W+KEY_W-1:POS_W];
  assign in_pay  = s_axis_tdata[POS_W+KEY_W+IN_PAY_W-1:POS_W+KEY_W];
  assign in_mode = mode_t'(s_axis_tuser);

  // Control and item registers
  state_t                   state, state_next;
  logic [CNT_W-1:0]         count;
  logic [ADDR_W-1:0]        cur;          // RAM address being read
  logic                     pend;         // read data arriving now is to be written back
  logic [ADDR_W-1:0]        pend_addr;
  logic                     chk;          // read data arriving now is to be compared
  logic                     hit;
  logic [PAYLOAD_WIDTH-1:0] found;
  mode_t                    op;
  logic [POS_W-1:0]         pos_q;
  logic [KEY_W-1:0]         key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  status_t                  status_q;

  // Output register
  logic                     out_valid;
  status_t                  out_status;
  logic [FOUND_W-1:0]       out_found;
  logic [OUT_CNT_W-1:0]     out_count;

  // RAM port
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [KEY_W-1:0]         rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_pay = ram_rdata[ENTRY_W-1:KEY_W];

  // Derived control
  logic              s_fire;
  logic              out_free;
  status_t           chk_status;
  logic [ADDR_W-1:0] last_addr;     // count - 1
  logic [CNT_W-1:0]  pos_ext;
  status_t           final_status;
  logic [CNT_W-1:0]  count_next;
  logic [FOUND_W-1:0] final_found;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign last_addr     = ADDR_W'(count - CNT_W'(1));
  assign pos_ext       = CNT_W'(in_pos);

  // Check an incoming item against the current count
  always_comb begin
    chk_status = STATUS_OK;
    case (in_mode)
      MODE_INSERT: begin
        if (count == CNT_W'(DEPTH)) begin
          chk_status = STATUS_FULL;
        end else if (pos_ext > count) begin
          chk_status = STATUS_RANGE;
        end
      end
      MODE_REMOVE: begin
        if (count == '0) begin
          chk_status = STATUS_EMPTY;
        end else if (pos_ext >= count) begin
          chk_status = STATUS_RANGE;
        end
      end
      MODE_FIND: begin
        if (count == '0) begin
          chk_status = STATUS_EMPTY;
        end
      end
      default: chk_status = STATUS_OK;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          if (chk_status != STATUS_OK) begin
            state_next = ST_DONE;
          end else begin
            case (in_mode)
              MODE_INSERT: state_next = (pos_ext == count) ? ST_DRAIN : ST_INS;
              MODE_REMOVE: state_next = (ADDR_W'(in_pos) == last_addr) ? ST_DRAIN : ST_DEL;
              MODE_FIND:   state_next = ST_FIND;
              default:     state_next = ST_DONE;
            endcase
          end
        end
      end
      ST_INS:   if (cur == ADDR_W'(pos_q)) state_next = ST_DRAIN;
      ST_DEL:   if (cur == last_addr) state_next = ST_DRAIN;
      ST_FIND:  if (cur == last_addr) state_next = ST_DRAIN;
      ST_DRAIN: if (!pend) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM write port and the result of the item
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    if (pend) begin
      // move the entry just read one place up or down
      ram_we = 1'b1;
    end else if (state == ST_DRAIN && op == MODE_INSERT) begin
      // drop the new entry into the gap
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(pos_q);
      ram_wdata = {pay_q, key_q};
    end

    final_status = status_q;
    final_found  = '0;
    count_next   = count;
    if (status_q == STATUS_OK) begin
      case (op)
        MODE_INSERT: count_next = count + CNT_W'(1);
        MODE_REMOVE: count_next = count - CNT_W'(1);
        MODE_FIND: begin
          if (hit) begin
            final_found = FOUND_W'(found);
          end else begin
            final_status = STATUS_NOTFOUND;
          end
        end
        default: count_next = count;
      endcase
    end
  end

  oale_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      chk       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_INS) || (state == ST_DEL);
      chk   <= (state == ST_FIND);
      if (state == ST_DONE && out_free) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and datapath registers
  always_ff @(posedge clk) begin
    if (s_fire) begin
      op       <= in_mode;
      pos_q    <= in_pos;
      key_q    <= in_key;
      pay_q    <= PAYLOAD_WIDTH'(in_pay);
      status_q <= chk_status;
      hit      <= 1'b0;
      found    <= '0;
      case (in_mode)
        MODE_INSERT: cur <= last_addr;
        MODE_REMOVE: cur <= ADDR_W'(in_pos) + ADDR_W'(1);
        default:     cur <= '0;
      endcase
    end else begin
      case (state)
        ST_INS:  cur <= cur - ADDR_W'(1);
        ST_DEL:  cur <= cur + ADDR_W'(1);
        ST_FIND: cur <= cur + ADDR_W'(1);
        default: cur <= cur;
      endcase
    end

    // Entry read at cur lands in the next cycle; remember where it goes
    pend_addr <= (state == ST_INS) ? cur + ADDR_W'(1) : cur - ADDR_W'(1);

    // Later matches overwrite earlier ones: keep the last hit
    if (chk && rd_key == key_q) begin
      hit   <= 1'b1;
      found <= rd_pay;
    end

    if (state == ST_DONE && out_free) begin
      out_status <= final_status;
      out_found  <= final_found;
      out_count  <= OUT_CNT_W'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = M_DATA_W'({out_count, out_found});

endmodule

`default_nettype wire

// ===== bench/tb_ordered_array_list_engine.sv =====
// Self-checking bench for ordered_array_list_engine: drives insert, remove and find
// transfers and compares each result with an in-bench model of the ordered list.
// Depends on oale_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
  import oale_pkg::*;

  // Mode 3 carries no operation; the engine answers it with an ok status
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [31:0] TAG_MASK = (PAYLOAD_WIDTH >= 32) ? 32'hFFFF_FFFF
                                   : ((32'd1 << PAYLOAD_WIDTH) - 32'd1);

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [FOUND_W-1:0]   found;
    logic [OUT_CNT_W-1:0] count;
  } list_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [MODE_W-1:0]     s_axis_tuser = '0;   // mode
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;   // position, key, payload, pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [STATUS_W-1:0]   m_axis_tuser;        // status
  logic [M_DATA_W-1:0]   m_axis_tdata;        // found_payload, entry_count, pad

  ordered_array_list_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Model of the list contents, advanced on each accepted transfer
  logic [KEY_W-1:0] list_keys [DEPTH];
  logic [31:0]      list_tags [DEPTH];
  int               list_len = 0;
  list_reply_t      predicted_replies [$];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned n_inserted = 0, n_removed = 0, n_hits = 0, n_full = 0;
  int unsigned n_range = 0, n_empty = 0, n_notfound = 0, n_spare = 0, peak_len = 0;

  // Key values that recur, so that finds hit and duplicates are common
  logic [KEY_W-1:0] key_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                     32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_00A5,
                                     32'h1234_5678, 32'hDEAD_BEEF};

  function automatic list_reply_t apply_list_op(logic [MODE_W-1:0] op,
                                                logic [POS_W-1:0] pos,
                                                logic [KEY_W-1:0] key,
                                                logic [31:0] tag);
    list_reply_t r;
    int          i;
    bit          hit;
    r.status = STATUS_OK;
    r.found  = '0;
    hit      = 1'b0;
    case (op)
      MODE_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = STATUS_FULL;
        end else if (int'(pos) > list_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (i = list_len; i > int'(pos); i--) begin
            list_keys[i] = list_keys[i-1];
            list_tags[i] = list_tags[i-1];
          end
          list_keys[pos[ADDR_W-1:0]] = key;
          list_tags[pos[ADDR_W-1:0]] = tag & TAG_MASK;
          list_len++;
        end
      end
      MODE_REMOVE: begin
        if (list_len == 0) begin
          r.status = STATUS_EMPTY;
        end else if (int'(pos) >= list_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < list_len; i++) begin
            list_keys[i] = list_keys[i+1];
            list_tags[i] = list_tags[i+1];
          end
          list_len--;
        end
      end
      MODE_FIND: begin
        if (list_len == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // Scan the whole list; the last match wins
          for (i = 0; i < list_len; i++) begin
            if (list_keys[i] == key) begin
              hit     = 1'b1;
              r.found = list_tags[i];
            end
          end
          if (!hit) r.status = STATUS_NOTFOUND;
        end
      end
      default: ;
    endcase
    r.count = list_len[OUT_CNT_W-1:0];
    return r;
  endfunction

  // Receiver: drop tready at random per the current stall rate
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check each result transfer against the oldest prediction, then predict
  // for any input transfer taken at the same edge.
  always @(posedge clk) begin
    list_reply_t want;
    list_reply_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.found  = m_axis_tdata[FOUND_W-1:0];
        got.count  = m_axis_tdata[FOUND_W +: OUT_CNT_W];
        if (predicted_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 40)
            $display("%0t: result with nothing expected: status %0d found %h count %0d",
                     $realtime, got.status, got.found, got.count);
        end else begin
          want = predicted_replies.pop_front();
          if (got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 40)
              $display("%0t: status expected %0d actual %0d",
                       $realtime, want.status, got.status);
          end
          if (got.found !== want.found) begin
            mismatch_count++;
            if (mismatch_count <= 40)
              $display("%0t: found_payload expected %h actual %h",
                       $realtime, want.found, got.found);
          end
          if (got.count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 40)
              $display("%0t: entry_count expected %0d actual %0d",
                       $realtime, want.count, got.count);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_list_op(s_axis_tuser, s_axis_tdata[POS_W-1:0],
                             s_axis_tdata[POS_W +: KEY_W],
                             s_axis_tdata[POS_W+KEY_W +: IN_PAY_W]);
        predicted_replies.push_back(want);
        case (want.status)
          STATUS_FULL:     n_full++;
          STATUS_RANGE:    n_range++;
          STATUS_EMPTY:    n_empty++;
          STATUS_NOTFOUND: n_notfound++;
          default: begin
            if (s_axis_tuser == MODE_INSERT) n_inserted++;
            else if (s_axis_tuser == MODE_REMOVE) n_removed++;
            else if (s_axis_tuser == MODE_FIND) n_hits++;
            else n_spare++;
          end
        endcase
        if (list_len > peak_len) peak_len = list_len;
      end
    end
  end

  // Send one item; idle cycles are drawn ahead of it at the sender's rate
  task automatic send_item(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [KEY_W-1:0] key, input logic [31:0] tag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tuser  = op;
    s_axis_tdata  = {{(S_DATA_W - POS_W - KEY_W - IN_PAY_W){1'b0}}, tag, key, pos};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic hold_until_drained();
    s_axis_tvalid = 1'b0;
    while (predicted_replies.size() != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(bit for_find);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (for_find && list_len > 0 && r < 50)
      return list_keys[ADDR_W'($urandom_range(0, list_len - 1))];
    if (r < 80) return key_pool[3'($urandom_range(0, 7))];
    return $urandom;
  endfunction

  // Favor head and tail, otherwise anywhere in 0..span
  function automatic logic [POS_W-1:0] pick_pos(int span);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return span[POS_W-1:0];
    return POS_W'($urandom_range(0, span));
  endfunction

  task automatic test_directed_corners();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(MODE_FIND,   7'd0,   32'h0000_0000, 32'h0);          // find on empty list
    send_item(MODE_REMOVE, 7'd0,   32'h0,         32'h0);          // remove on empty list
    send_item(MODE_REMOVE, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_SPARE,  7'd5,   $urandom,      $urandom);       // mode with no meaning
    send_item(MODE_INSERT, 7'd1,   32'h1,         32'h1);          // past the end
    send_item(MODE_INSERT, 7'd127, 32'h1,         32'h1);
    send_item(MODE_INSERT, 7'd0,   32'h8000_0000, 32'h0000_0000);
    send_item(MODE_INSERT, 7'd1,   32'h7FFF_FFFF, 32'hFFFF_FFFF);  // tail
    send_item(MODE_INSERT, 7'd0,   32'h0000_0000, 32'h0000_1234);  // head
    send_item(MODE_INSERT, 7'd1,   32'h7FFF_FFFF, 32'hA5A5_A5A5);  // duplicate key
    send_item(MODE_FIND,   7'd0,   32'h7FFF_FFFF, 32'h0);          // last match wins
    send_item(MODE_FIND,   7'd0,   32'h8000_0000, 32'h0);          // hit on a zero tag
    send_item(MODE_FIND,   7'd0,   32'h1234_5678, 32'h0);          // no match
    send_item(MODE_SPARE,  7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_REMOVE, 7'd4,   32'h0,         32'h0);          // position equals count
    send_item(MODE_REMOVE, 7'd3,   32'h0,         32'h0);          // tail
    send_item(MODE_FIND,   7'd0,   32'h7FFF_FFFF, 32'h0);
    send_item(MODE_REMOVE, 7'd0,   32'h0,         32'h0);          // head
    send_item(MODE_REMOVE, 7'd64,  32'h0,         32'h0);
    send_item(MODE_INSERT, 7'd3,   32'h0,         32'h0);
    send_item(MODE_REMOVE, 7'd0,   32'h0,         32'h0);
    send_item(MODE_REMOVE, 7'd0,   32'h0,         32'h0);
    send_item(MODE_FIND,   7'd0,   32'h7FFF_FFFF, 32'h0);
  endtask

  // Fill to capacity, poke the full list, then drain it to empty
  task automatic test_fill_to_capacity();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    while (list_len < DEPTH) send_item(MODE_INSERT, pick_pos(list_len), pick_key(0), $urandom);
    send_item(MODE_INSERT, 7'd0,   pick_key(0), $urandom);
    send_item(MODE_INSERT, 7'd64,  pick_key(0), $urandom);
    send_item(MODE_INSERT, 7'd127, pick_key(0), $urandom);  // full is reported before range
    send_item(MODE_FIND,   7'd0,   pick_key(1), 32'h0);
    send_item(MODE_FIND,   7'd0,   $urandom,    32'h0);
    send_item(MODE_REMOVE, 7'd64,  32'h0,       32'h0);
    send_item(MODE_REMOVE, 7'd63,  32'h0,       32'h0);
    send_item(MODE_INSERT, 7'd63,  pick_key(0), $urandom);
    send_item(MODE_REMOVE, 7'd0,   32'h0,       32'h0);
    send_item(MODE_INSERT, 7'd0,   pick_key(0), $urandom);
    while (list_len > 0) send_item(MODE_REMOVE, pick_pos(list_len - 1), $urandom, $urandom);
  endtask

  // Mixed traffic; the mix tilts toward inserts until the list fills and
  // toward removes until it empties, so every fill level gets visited.
  task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
    int          n;
    int unsigned r;
    bit          growing;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    growing = (list_len < DEPTH / 2);
    for (n = 0; n < n_items; n++) begin
      if (list_len >= DEPTH) growing = 1'b0;
      if (list_len == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 5)
        send_item(MODE_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)),
                  $urandom, $urandom);
      else if (r < (growing ? 60 : 20))
        send_item(MODE_INSERT, pick_pos(list_len), pick_key(0), $urandom);
      else if (r < 75)
        send_item(MODE_REMOVE,
                  (list_len == 0) ? POS_W'($urandom_range(0, 127)) : pick_pos(list_len - 1),
                  $urandom, $urandom);
      else
        send_item(MODE_FIND, POS_W'($urandom_range(0, 127)), pick_key(1), $urandom);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_corners();
    hold_until_drained();
    test_fill_to_capacity();
    hold_until_drained();
    test_random_traffic(450, 0, 0);
    hold_until_drained();
    test_random_traffic(450, 55, 0);
    hold_until_drained();
    test_random_traffic(450, 0, 55);
    hold_until_drained();
    test_random_traffic(450, 27, 27);
    hold_until_drained();

    // Allow the longest operation to surface any stray result
    repeat (DEPTH + 8) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d results never arrived", $realtime, predicted_replies.size());
    end

    $display("Covered %0d inserts, %0d removes, %0d find hits, %0d misses, %0d spare modes;",
             n_inserted, n_removed, n_hits, n_notfound, n_spare);
    $display("rejected %0d full, %0d range, %0d empty; longest list %0d of %0d entries.",
             n_full, n_range, n_empty, peak_len, DEPTH);
    if (mismatch_count == 0) begin
      $display("tb_ordered_array_list_engine: clean");
    end else begin
      $display("tb_ordered_array_list_engine: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("tb_ordered_array_list_engine: errors");
    $finish;
  end

endmodule
